[design/acocd_pkg.sv]
`default_nettype none

package acocd_pkg;

	localparam int KEY_W = 64;
	localparam int LEN_W = 17;
	localparam int AGE_W = 32;
	localparam int SLOT_W = 4;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	// search record handed from cell to cell
	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic             found;
		logic [LEN_W-1:0] hit_len;
		logic             free_found;
		logic [AGE_W-1:0] best_age;
	} rec_t;

	// update broadcast to every cell; act is set when a hit or an insert commits
	typedef struct packed {
		logic             act;
		logic             wr;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

endpackage

`default_nettype wire

[design/acocd_cell.sv]
`default_nettype none

module acocd_cell #(
	parameter int IDX_W = 4,
	parameter int IDX   = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  vld_in,
	input  acocd_pkg::rec_t      rec_in,
	input  wire [IDX_W-1:0]      hit_idx_in,
	input  wire [IDX_W-1:0]      free_idx_in,
	input  wire [IDX_W-1:0]      best_idx_in,
	output logic                 vld_out,
	output acocd_pkg::rec_t      rec_out,
	output logic [IDX_W-1:0]     hit_idx_out,
	output logic [IDX_W-1:0]     free_idx_out,
	output logic [IDX_W-1:0]     best_idx_out,
	input  acocd_pkg::upd_t      upd,
	input  wire [IDX_W-1:0]      upd_idx
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                        valid_q;
	logic [acocd_pkg::KEY_W-1:0] key_q;
	logic [acocd_pkg::LEN_W-1:0] len_q;
	logic [acocd_pkg::AGE_W-1:0] age_q;

	acocd_pkg::rec_t  rec_nxt;
	logic [IDX_W-1:0] hit_idx_nxt;
	logic [IDX_W-1:0] free_idx_nxt;
	logic [IDX_W-1:0] best_idx_nxt;
	logic             tgt;

	always_comb begin
		rec_nxt      = rec_in;
		hit_idx_nxt  = hit_idx_in;
		free_idx_nxt = free_idx_in;
		best_idx_nxt = best_idx_in;
		// keep the first match and the first free slot
		if (!rec_in.found && valid_q && key_q == rec_in.key) begin
			rec_nxt.found   = 1'b1;
			rec_nxt.hit_len = len_q;
			hit_idx_nxt     = MY_IDX;
		end
		if (!rec_in.free_found && !valid_q) begin
			rec_nxt.free_found = 1'b1;
			free_idx_nxt       = MY_IDX;
		end
		// strict compare: ties stay with the earlier slot
		if (age_q > rec_in.best_age) begin
			rec_nxt.best_age = age_q;
			best_idx_nxt     = MY_IDX;
		end
	end

	assign tgt = (upd_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	// hold the record once the item has passed, so the tail can be read later
	always_ff @(posedge clk) begin
		if (vld_in) begin
			rec_out      <= rec_nxt;
			hit_idx_out  <= hit_idx_nxt;
			free_idx_out <= free_idx_nxt;
			best_idx_out <= best_idx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (upd.act) begin
			if (tgt && upd.wr) begin
				valid_q <= 1'b1;
			end
			if (tgt) begin
				age_q <= acocd_pkg::AGE_W'(1);
			end else if (age_q != acocd_pkg::AGE_MAX) begin
				age_q <= age_q + acocd_pkg::AGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.act && upd.wr && tgt) begin
			key_q <= upd.key;
			len_q <= upd.len;
		end
	end

endmodule

`default_nettype wire

[design/age_counter_object_cache_directory.sv]
`default_nettype none

// Directory of a small fully associative object cache with age-counter
// replacement. A request carries func (lookup or insert), a 64-bit key and an
// object length; every request gives exactly one response. The slots sit in a
// row of cells and a search record steps through one cell per cycle. Once the
// record has passed the chain of cells, the outcome is settled in a commit
// state. The age and slot update of a hit or an insert commits on the edge
// that loads the response. One request is in the directory at a time. A new
// request is taken as soon as the previous one has committed, even while its
// response still waits. A response held by rsp_stall blocks the commit of the
// request behind it.
module age_counter_object_cache_directory #(
	parameter int SLOTS   = 10,
	parameter int MAX_LEN = 102400
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_stall,
	input  wire                            func,
	input  wire [acocd_pkg::KEY_W-1:0]     key,
	input  wire [acocd_pkg::LEN_W-1:0]     object_len,
	output logic                           rsp_valid,
	input  wire                            rsp_stall,
	output logic                           hit,
	output logic [acocd_pkg::SLOT_W-1:0]   slot,
	output logic [acocd_pkg::LEN_W-1:0]    stored_len,
	output logic                           evicted
);

	localparam int IDX_W = $clog2(SLOTS);

	acocd_pkg::state_t state_q, state_nxt;

	logic             chain_vld  [SLOTS+1];
	acocd_pkg::rec_t  chain_rec  [SLOTS+1];
	logic [IDX_W-1:0] chain_hit  [SLOTS+1];
	logic [IDX_W-1:0] chain_free [SLOTS+1];
	logic [IDX_W-1:0] chain_best [SLOTS+1];

	acocd_pkg::upd_t  upd;
	logic [IDX_W-1:0] upd_idx;

	logic accept;
	logic commit;
	logic oversized;
	logic rsp_hit, rsp_evicted;
	logic [IDX_W-1:0] rsp_idx;
	logic [acocd_pkg::LEN_W-1:0] rsp_len;

	acocd_pkg::rec_t tail;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != acocd_pkg::ST_IDLE);

	assign chain_vld[0]  = accept;
	assign chain_hit[0]  = '0;
	assign chain_free[0] = '0;
	assign chain_best[0] = '0;
	always_comb begin
		chain_rec[0]            = '0;
		chain_rec[0].func       = func;
		chain_rec[0].key        = key;
		chain_rec[0].len        = object_len;
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		acocd_cell #(
			.IDX_W(IDX_W),
			.IDX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.vld_in      (chain_vld[i]),
			.rec_in      (chain_rec[i]),
			.hit_idx_in  (chain_hit[i]),
			.free_idx_in (chain_free[i]),
			.best_idx_in (chain_best[i]),
			.vld_out     (chain_vld[i+1]),
			.rec_out     (chain_rec[i+1]),
			.hit_idx_out (chain_hit[i+1]),
			.free_idx_out(chain_free[i+1]),
			.best_idx_out(chain_best[i+1]),
			.upd         (upd),
			.upd_idx     (upd_idx)
		);
	end

	assign tail = chain_rec[SLOTS];

	assign oversized = (32'(tail.len) > 32'(MAX_LEN));
	assign commit    = (state_q == acocd_pkg::ST_COMMIT) && (!rsp_valid || !rsp_stall);

	// decide the outcome from the finished search record
	always_comb begin
		rsp_hit     = 1'b0;
		rsp_evicted = 1'b0;
		rsp_idx     = '0;
		rsp_len     = '0;
		upd         = '0;
		upd.key     = tail.key;
		upd.len     = tail.len;
		if (tail.func == acocd_pkg::FUNC_LOOKUP) begin
			if (tail.found) begin
				rsp_hit = 1'b1;
				rsp_idx = chain_hit[SLOTS];
				rsp_len = tail.hit_len;
				upd.act = commit;
			end
		end else if (!oversized) begin
			rsp_evicted = !tail.free_found;
			rsp_idx     = tail.free_found ? chain_free[SLOTS] : chain_best[SLOTS];
			rsp_len     = tail.len;
			upd.act     = commit;
			upd.wr      = 1'b1;
		end
		upd_idx = rsp_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acocd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			acocd_pkg::ST_IDLE: begin
				if (accept) state_nxt = acocd_pkg::ST_SCAN;
			end
			acocd_pkg::ST_SCAN: begin
				if (chain_vld[SLOTS]) state_nxt = acocd_pkg::ST_COMMIT;
			end
			acocd_pkg::ST_COMMIT: begin
				if (commit) state_nxt = acocd_pkg::ST_IDLE;
			end
			default: state_nxt = acocd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (commit) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit        <= rsp_hit;
			slot       <= acocd_pkg::SLOT_W'(rsp_idx);
			stored_len <= rsp_len;
			evicted    <= rsp_evicted;
		end
	end

endmodule

`default_nettype wire

[design/acocd_chk.sv]
`default_nettype none

module acocd_chk #(
	parameter int SLOTS = 10
) (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_stall,
	input wire        rsp_valid,
	input wire        rsp_stall,
	input wire        hit,
	input wire [3:0]  slot,
	input wire        evicted
);

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a previous item is in flight");

	// a new response only appears at the end of a busy period
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without an item in flight");

	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(hit && evicted))
		else $error("hit and eviction reported together");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (hit || evicted) |-> (SLOTS > 16) || (32'(slot) < 32'(SLOTS)))
		else $error("slot beyond the directory");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(slot) && $stable(hit))
		else $error("stalled response changed");

endmodule

bind age_counter_object_cache_directory acocd_chk #(.SLOTS(SLOTS)) u_acocd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.hit      (hit),
	.slot     (slot),
	.evicted  (evicted)
);

`default_nettype wire

[test/tb_age_counter_object_cache_directory.sv]
`default_nettype none

module tb_age_counter_object_cache_directory;

	localparam int NSLOTS = 10;
	localparam int MAX_OBJ = 102400;
	localparam int POOL = 16;
	localparam int RAND_CHUNK = 300;

	typedef struct packed {
		logic                         hit;
		logic [acocd_pkg::SLOT_W-1:0] slot;
		logic [acocd_pkg::LEN_W-1:0]  len;
		logic                         evicted;
	} dir_rsp_t;

	class dir_scoreboard;
		logic                        used [NSLOTS];
		logic [acocd_pkg::KEY_W-1:0] tag_store [NSLOTS];
		logic [acocd_pkg::LEN_W-1:0] len_store [NSLOTS];
		logic [acocd_pkg::AGE_W-1:0] age_store [NSLOTS];
		dir_rsp_t                    pending_q [$];
		int                          errors;

		function new();
			errors = 0;
			for (int i = 0; i < NSLOTS; i++) begin
				used[i] = 1'b0;
				tag_store[i] = '0;
				len_store[i] = '0;
				age_store[i] = '0;
			end
		endfunction

		// work out the directory's answer to an accepted item and update the copy
		function void note_request(logic f, logic [acocd_pkg::KEY_W-1:0] k,
				logic [acocd_pkg::LEN_W-1:0] l);
			dir_rsp_t r;
			int pick;
			r = '0;
			pick = -1;
			if (f == acocd_pkg::FUNC_LOOKUP) begin
				for (int i = 0; i < NSLOTS && pick < 0; i++)
					if (used[i] && tag_store[i] == k)
						pick = i;
				if (pick >= 0) begin
					r.hit = 1'b1;
					r.slot = pick[acocd_pkg::SLOT_W-1:0];
					r.len = len_store[pick];
				end
			end else if (l <= MAX_OBJ) begin
				for (int i = 0; i < NSLOTS && pick < 0; i++)
					if (!used[i])
						pick = i;
				if (pick < 0) begin
					// evict the first slot holding the greatest age
					pick = 0;
					for (int i = 1; i < NSLOTS; i++)
						if (age_store[i] > age_store[pick])
							pick = i;
					r.evicted = 1'b1;
				end
				used[pick] = 1'b1;
				tag_store[pick] = k;
				len_store[pick] = l;
				r.slot = pick[acocd_pkg::SLOT_W-1:0];
				r.len = l;
			end
			if (pick >= 0) begin
				age_store[pick] = '0;
				for (int i = 0; i < NSLOTS; i++)
					if (age_store[i] != acocd_pkg::AGE_MAX)
						age_store[i] = age_store[i] + 1'b1;
			end
			pending_q.push_back(r);
		endfunction

		function void check_response(logic h, logic [acocd_pkg::SLOT_W-1:0] s,
				logic [acocd_pkg::LEN_W-1:0] l, logic e);
			dir_rsp_t want;
			if (pending_q.size() == 0) begin
				$error("response with no item outstanding: hit %0d slot %0d len %0d evicted %0d",
					h, s, l, e);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (h !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, h);
				errors++;
			end
			if (s !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, s);
				errors++;
			end
			if (l !== want.len) begin
				$error("stored_len: expected %0d, got %0d", want.len, l);
				errors++;
			end
			if (e !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, e);
				errors++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_stall;
	logic                         func = acocd_pkg::FUNC_LOOKUP;
	logic [acocd_pkg::KEY_W-1:0]  key = '0;
	logic [acocd_pkg::LEN_W-1:0]  object_len = '0;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	logic                         hit;
	logic [acocd_pkg::SLOT_W-1:0] slot;
	logic [acocd_pkg::LEN_W-1:0]  stored_len;
	logic                         evicted;

	dir_scoreboard                sb;
	logic [acocd_pkg::KEY_W-1:0]  key_pool [POOL];
	int                           send_idle_pct = 7;
	int                           rcv_idle_pct = 7;
	int                           rsp_hold = 0;

	age_counter_object_cache_directory #(
		.SLOTS  (NSLOTS),
		.MAX_LEN(MAX_OBJ)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.key       (key),
		.object_len(object_len),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.slot      (slot),
		.stored_len(stored_len),
		.evicted   (evicted)
	);

	always #5 clk = ~clk;

	// receiver: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_stall = 1'b1;
			rsp_hold = rsp_hold - 1;
		end else begin
			rsp_stall = ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(hit, slot, stored_len, evicted);
	end

	// hold the item until it is taken; valid stays high into the next item
	task automatic send_request(input logic f, input logic [acocd_pkg::KEY_W-1:0] k,
			input logic [acocd_pkg::LEN_W-1:0] l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		func = f;
		key = k;
		object_len = l;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(f, k, l);
	endtask

	task automatic send_random();
		logic                        f;
		logic [acocd_pkg::KEY_W-1:0] k;
		logic [acocd_pkg::LEN_W-1:0] l;
		int                          r;
		f = ($urandom_range(99) < 40) ? acocd_pkg::FUNC_INSERT : acocd_pkg::FUNC_LOOKUP;
		if ($urandom_range(99) < 75) begin
			k = key_pool[$urandom_range(POOL-1)];
		end else begin
			k = {$urandom, $urandom};
			// fresh inserted keys join the pool so later lookups can find them
			if (f == acocd_pkg::FUNC_INSERT)
				key_pool[$urandom_range(POOL-1)] = k;
		end
		r = $urandom_range(99);
		if (r < 6)
			l = acocd_pkg::LEN_W'($urandom_range((1 << acocd_pkg::LEN_W) - 1, MAX_OBJ + 1));
		else if (r < 10)
			l = acocd_pkg::LEN_W'(MAX_OBJ);
		else
			l = acocd_pkg::LEN_W'($urandom_range(MAX_OBJ));
		send_request(f, k, l);
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		sb = new();
		for (int i = 0; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty miss, extremes, oversize, fill, evict, duplicates
		send_request(acocd_pkg::FUNC_LOOKUP, '0, '1);
		send_request(acocd_pkg::FUNC_INSERT, '1, '0);
		send_request(acocd_pkg::FUNC_INSERT, '0, acocd_pkg::LEN_W'(MAX_OBJ));
		send_request(acocd_pkg::FUNC_INSERT, 64'h5555_5555_5555_5555,
			acocd_pkg::LEN_W'(MAX_OBJ + 1));
		send_request(acocd_pkg::FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, '1);
		send_request(acocd_pkg::FUNC_LOOKUP, '1, '0);
		send_request(acocd_pkg::FUNC_LOOKUP, '0, '1);
		send_request(acocd_pkg::FUNC_LOOKUP, 64'hA5A5_A5A5_A5A5_A5A5, '0);
		for (int i = 2; i < NSLOTS; i++)
			send_request(acocd_pkg::FUNC_INSERT, 64'h100 + i, acocd_pkg::LEN_W'(i * 1000));
		send_request(acocd_pkg::FUNC_INSERT, 64'hDEAD_BEEF_0000_0001, 17'd77);
		send_request(acocd_pkg::FUNC_INSERT, 64'h103, 17'd4242);
		send_request(acocd_pkg::FUNC_LOOKUP, 64'h103, '0);
		send_request(acocd_pkg::FUNC_LOOKUP, '1, '0);
		send_request(acocd_pkg::FUNC_INSERT, 64'h4242, 17'd1);
		send_request(acocd_pkg::FUNC_LOOKUP, 64'h4242, '1);

		for (int n = 0; n < RAND_CHUNK; n++)
			send_random();

		// pause the sender until the directory has answered everything
		@(negedge clk);
		req_valid = 1'b0;
		drain();

		// no idling on either side
		send_idle_pct = 0;
		rcv_idle_pct = 0;
		for (int n = 0; n < RAND_CHUNK; n++)
			send_random();

		send_idle_pct = 7;
		rcv_idle_pct = 7;
		rsp_hold = 80;
		for (int n = 0; n < RAND_CHUNK; n++)
			send_random();

		@(negedge clk);
		req_valid = 1'b0;
		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
